@@ hw/rtl/hsl_pkg.sv @@
package hsl_pkg;

  localparam int HUE_BITS       = 11;
  localparam int FRAC_BITS      = 9;
  localparam int SIXTH_SHIFT    = 8;
  localparam int NUM_CH         = 3;

  localparam logic [HUE_BITS-1:0] HUE_STEPS      = 11'd1536;
  localparam logic [HUE_BITS-1:0] HUE_THIRD      = 11'd512;
  localparam logic [HUE_BITS-1:0] HUE_SIXTH      = 11'd256;
  localparam logic [HUE_BITS-1:0] HUE_HALF       = 11'd768;
  localparam logic [HUE_BITS-1:0] HUE_TWO_THIRDS = 11'd1024;

  typedef logic [HUE_BITS-1:0]  hue_t;
  typedef logic [FRAC_BITS-1:0] frac_t;

  // blend weight of the high level for a shifted hue in 0..1535
  function automatic frac_t hue_frac(hue_t t);
    hue_t d;
    d = HUE_TWO_THIRDS - t;
    if (t < HUE_SIXTH) begin
      return frac_t'(t);
    end else if (t < HUE_HALF) begin
      return frac_t'(HUE_SIXTH);
    end else if (t < HUE_TWO_THIRDS) begin
      return frac_t'(d);
    end else begin
      return '0;
    end
  endfunction

endpackage

@@ hw/rtl/hsl_in_if.sv @@
interface hsl_in_if import hsl_pkg::*; #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [HUE_BITS-1:0]     hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

@@ hw/rtl/hsl_out_if.sv @@
interface hsl_out_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ hw/rtl/hsl_front.sv @@
module hsl_front import hsl_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [HUE_BITS-1:0]       hue,
  input  logic [CHANNEL_BITS-1:0]   saturation,
  input  logic [CHANNEL_BITS-1:0]   lightness,
  output logic                      out_valid,
  input  logic                      out_ready,
  output frac_t                     frac [NUM_CH],
  output logic [CHANNEL_BITS-1:0]   light,
  output logic [2*CHANNEL_BITS-1:0] spread
);
  localparam int B = CHANNEL_BITS;
  localparam logic [B-1:0] CMAX = {B{1'b1}};

  hue_t                h;
  hue_t                t [NUM_CH];
  logic                dark;
  logic [B-1:0]        sel;
  logic [2*B-1:0]      spread_next;
  logic                valid;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_comb begin
    h = (hue >= HUE_STEPS) ? hue - HUE_STEPS : hue;
    t[0] = (h + HUE_THIRD >= HUE_STEPS) ? h + HUE_THIRD - HUE_STEPS : h + HUE_THIRD;
    t[1] = h;
    t[2] = (h >= HUE_THIRD) ? h - HUE_THIRD : h + HUE_TWO_THIRDS;
    dark = {lightness, 1'b0} < {1'b0, CMAX};
    sel  = dark ? lightness : CMAX - lightness;
    spread_next = (2*B)'(saturation) * (2*B)'(sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int k = 0; k < NUM_CH; k++) begin
        frac[k] <= hue_frac(t[k]);
      end
      light  <= lightness;
      spread <= spread_next;
    end
  end
endmodule

@@ hw/rtl/hsl_blend.sv @@
module hsl_blend import hsl_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  frac_t                     frac [NUM_CH],
  input  logic [CHANNEL_BITS-1:0]   light,
  input  logic [2*CHANNEL_BITS-1:0] spread,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2*CHANNEL_BITS-1:0] level [NUM_CH]
);
  localparam int B  = CHANNEL_BITS;
  localparam int W  = 2*B;
  localparam int PW = W + 1 + FRAC_BITS;
  localparam int SW = PW - SIXTH_SHIFT;

  logic           valid2, valid3;
  logic           rdy2, rdy3;
  logic [W-1:0]   lm;
  logic [W-1:0]   low_next;
  logic [W:0]     diff;
  logic [W-1:0]   low;
  logic [PW-1:0]  prod [NUM_CH];
  logic [SW-1:0]  sum  [NUM_CH];

  assign rdy3      = !valid3 || out_ready;
  assign rdy2      = !valid2 || rdy3;
  assign in_ready  = rdy2;
  assign out_valid = valid3;

  always_comb begin
    lm       = {light, {B{1'b0}}} - W'(light);
    low_next = lm - spread;
    diff     = {spread, 1'b0};
    for (int k = 0; k < NUM_CH; k++) begin
      sum[k] = SW'(low) + prod[k][PW-1:SIXTH_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (rdy2) valid2 <= in_valid;
      if (rdy3) valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && in_valid) begin
      low <= low_next;
      for (int k = 0; k < NUM_CH; k++) begin
        prod[k] <= PW'(diff) * PW'(frac[k]);
      end
    end
    if (rdy3 && valid2) begin
      for (int k = 0; k < NUM_CH; k++) begin
        level[k] <= sum[k][W-1:0];
      end
    end
  end
endmodule

@@ hw/rtl/hsl_div.sv @@
module hsl_div import hsl_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2*CHANNEL_BITS-1:0] level [NUM_CH],
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CHANNEL_BITS-1:0]   chan [NUM_CH]
);
  localparam int B = CHANNEL_BITS;
  localparam logic [B:0] CMAX = {1'b0, {B{1'b1}}};

  logic         valid;
  logic [B:0]   fold [NUM_CH];
  logic [B-1:0] quo  [NUM_CH];

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // divide by 2^B-1: y = a*2^B + b = a*M + (a + b), with a + b < 2M
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      fold[k] = {1'b0, level[k][2*B-1:B]} + {1'b0, level[k][B-1:0]};
      quo[k]  = level[k][2*B-1:B] + B'(fold[k] >= CMAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int k = 0; k < NUM_CH; k++) begin
        chan[k] <= quo[k];
      end
    end
  end
endmodule

@@ hw/rtl/hsl_to_rgb.sv @@
// HSL to RGB color converter. Takes hue (1/1536 turn, values above 1535 wrap),
// saturation and lightness (1/(2^CHANNEL_BITS-1) units) and returns truncated
// red, green and blue levels. Fully pipelined: one transaction per clock while
// the output is ready, through four register stages (helper-level multiply, blend
// multiply, blend add, divide by the channel maximum). Each stage holds its own
// valid bit, so bubbles collapse; a stalled output holds each earlier stage only
// once that stage is full.
module hsl_to_rgb import hsl_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input logic            clk,
  input logic            rst,
  hsl_in_if.sink         hsl,
  hsl_out_if.source      rgb
);
  localparam int B = CHANNEL_BITS;

  logic           v1, r1, v2, r2;
  frac_t          frac [NUM_CH];
  logic [B-1:0]   light;
  logic [2*B-1:0] spread;
  logic [2*B-1:0] level [NUM_CH];
  logic [B-1:0]   chan  [NUM_CH];

  hsl_front #(.CHANNEL_BITS(B)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (hsl.valid),
    .in_ready   (hsl.ready),
    .hue        (hsl.hue),
    .saturation (hsl.saturation),
    .lightness  (hsl.lightness),
    .out_valid  (v1),
    .out_ready  (r1),
    .frac       (frac),
    .light      (light),
    .spread     (spread)
  );

  hsl_blend #(.CHANNEL_BITS(B)) u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r1),
    .frac      (frac),
    .light     (light),
    .spread    (spread),
    .out_valid (v2),
    .out_ready (r2),
    .level     (level)
  );

  hsl_div #(.CHANNEL_BITS(B)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r2),
    .level     (level),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .chan      (chan)
  );

  assign rgb.red   = chan[0];
  assign rgb.green = chan[1];
  assign rgb.blue  = chan[2];
endmodule
